FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file hlpt_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hlpt check failed");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hlpt check failed");

// next-cycle implication, checked during reset too
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hlpt check failed");

`endif

FILE: rtl/core/hlpt_pkg.sv
// types and constants of the hashed linear probe table
package hlpt_pkg;

  localparam int KEY_W  = 32;
  localparam int LEN_W  = 12;
  localparam int OFF_W  = 32;
  localparam int ST_W   = 3;
  localparam int SLOT_W = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_HIT       = 3'd3;
  localparam logic [ST_W-1:0] ST_MISS      = 3'd4;

  localparam logic [KEY_W-1:0] HASH_MUL1 = 32'h7feb352d;
  localparam logic [KEY_W-1:0] HASH_MUL2 = 32'h846ca68b;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] off;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
    logic [OFF_W-1:0]  offset;
  } res_t;

endpackage

FILE: rtl/core/hlpt_front.sv
// front end: takes commands, hashes the key and reduces it to a home slot
module hlpt_front import hlpt_pkg::*; #(
  parameter int TABLE_SLOTS = 256,
  localparam int IW = $clog2(TABLE_SLOTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  cmd_t          cmd_in,
  input  logic          clearing,
  output logic          busy,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd,
  output logic [IW-1:0] q_home
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_H1   = 3'd1;
  localparam logic [2:0] F_H2   = 3'd2;
  localparam logic [2:0] F_H3   = 3'd3;
  localparam logic [2:0] F_MOD  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]       state_r;
  cmd_t             cmd_r;
  logic [KEY_W-1:0] v_r;
  logic [IW-1:0]    rem_r;
  logic [IW-1:0]    rem_nxt;
  logic [1:0]       mcnt_r;
  logic [IW:0]      r;
  logic             accept;

  assign busy   = (state_r != F_IDLE) || clearing;
  assign accept = start && !busy;
  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_cmd  = cmd_r;
  assign q_home = rem_r;

  // remainder by the slot count, one byte of the hash per cycle
  always_comb begin
    r = {1'b0, rem_r};
    for (int i = 0; i < 8; i++) begin
      r = {r[IW-1:0], v_r[KEY_W-1-i]};
      if (r >= (IW+1)'(TABLE_SLOTS)) begin
        r = r - (IW+1)'(TABLE_SLOTS);
      end
    end
    rem_nxt = r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_r <= F_H1;
          end
        end
        F_H1:   state_r <= F_H2;
        F_H2:   state_r <= F_H3;
        F_H3:   state_r <= F_MOD;
        F_MOD: begin
          if (mcnt_r == 2'd3) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          cmd_r <= cmd_in;
          v_r   <= cmd_in.key;
        end
      end
      F_H1: v_r <= KEY_W'((v_r ^ (v_r >> 16)) * HASH_MUL1);
      F_H2: v_r <= KEY_W'((v_r ^ (v_r >> 15)) * HASH_MUL2);
      F_H3: begin
        v_r    <= v_r ^ (v_r >> 16);
        rem_r  <= '0;
        mcnt_r <= 2'd0;
      end
      F_MOD: begin
        rem_r  <= rem_nxt;
        v_r    <= v_r << 8;
        mcnt_r <= mcnt_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/hlpt_queue.sv
// two-entry queue between front and back end
module hlpt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/hlpt_back.sv
// back end: slot memories, clearing pass and the linear probe walk
module hlpt_back import hlpt_pkg::*; #(
  parameter int TABLE_SLOTS = 256,
  localparam int IW = $clog2(TABLE_SLOTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  output logic          q_pop,
  input  cmd_t          q_cmd,
  input  logic [IW-1:0] q_home,
  output logic          clearing,
  output logic          res_valid,
  output res_t          res
);

  localparam logic B_IDLE  = 1'b0;
  localparam logic B_PROBE = 1'b1;

  logic [KEY_W-1:0] key_mem [TABLE_SLOTS];
  logic [LEN_W-1:0] len_mem [TABLE_SLOTS];
  logic [OFF_W-1:0] off_mem [TABLE_SLOTS];

  logic             state_r;
  cmd_t             cmd_r;
  logic [IW-1:0]    pos_r;
  logic [IW-1:0]    cnt_r;
  logic             clr_act_r;
  logic [IW-1:0]    clr_cnt_r;
  logic [KEY_W-1:0] rd_key_r;
  logic [LEN_W-1:0] rd_len_r;
  logic [OFF_W-1:0] rd_off_r;
  logic             res_valid_r;
  res_t             res_r;
  res_t             res_nxt;

  logic [IW-1:0]    pos_inc;
  logic [IW-1:0]    rd_addr;
  logic             slot_empty;
  logic             slot_match;
  logic             probing;
  logic             done;
  logic             ins_we;
  logic             key_we;
  logic [IW-1:0]    wr_addr;

  assign clearing   = clr_act_r;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  assign pos_inc    = (pos_r == IW'(TABLE_SLOTS - 1)) ? '0 : IW'(pos_r + 1'b1);
  assign q_pop      = (state_r == B_IDLE) && !q_empty && !clr_act_r;
  assign rd_addr    = (state_r == B_IDLE) ? q_home : pos_inc;
  assign probing    = (state_r == B_PROBE);
  assign slot_empty = (rd_key_r == '0);
  assign slot_match = (rd_key_r == cmd_r.key);
  assign done       = probing &&
                      (slot_empty || slot_match || (cnt_r == IW'(TABLE_SLOTS - 1)));
  assign ins_we     = probing && slot_empty && (cmd_r.op == OP_INSERT);
  assign key_we     = clr_act_r || ins_we;
  assign wr_addr    = clr_act_r ? clr_cnt_r : pos_r;

  always_comb begin
    res_nxt        = '0;
    if (slot_empty) begin
      if (cmd_r.op == OP_INSERT) begin
        res_nxt.status = ST_INSERTED;
        res_nxt.slot   = SLOT_W'(pos_r);
      end else begin
        res_nxt.status = ST_MISS;
      end
    end else if (slot_match) begin
      res_nxt.slot = SLOT_W'(pos_r);
      if (cmd_r.op == OP_INSERT) begin
        res_nxt.status = ST_DUPLICATE;
      end else begin
        res_nxt.status = ST_HIT;
        res_nxt.length = rd_len_r;
        res_nxt.offset = rd_off_r;
      end
    end else begin
      res_nxt.status = (cmd_r.op == OP_INSERT) ? ST_FULL : ST_MISS;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= clr_act_r ? '0 : cmd_r.key;
    end
    if (ins_we) begin
      len_mem[pos_r] <= cmd_r.len;
      off_mem[pos_r] <= cmd_r.off;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_len_r <= len_mem[rd_addr];
    rd_off_r <= off_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      clr_act_r   <= 1'b1;
      clr_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= done;
      if (clr_act_r) begin
        if (clr_cnt_r == IW'(TABLE_SLOTS - 1)) begin
          clr_act_r <= 1'b0;
        end
        clr_cnt_r <= IW'(clr_cnt_r + 1'b1);
      end
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            state_r <= B_PROBE;
          end
        end
        B_PROBE: begin
          if (done) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
      pos_r <= q_home;
      cnt_r <= '0;
    end else if (probing && !done) begin
      pos_r <= pos_inc;
      cnt_r <= IW'(cnt_r + 1'b1);
    end
    if (done) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: rtl/core/hashed_linear_probe_table.sv
// top level of the hashed linear probe table
// Open-addressing hash table of TABLE_SLOTS slots, each a 32-bit key with a
// 12-bit length and 32-bit offset payload; key 0 marks an empty slot. A command
// is taken at a clock edge with start high and busy low. After reset busy stays
// high while the key memory is swept to empty. The front end then holds busy
// after each accepted command through three hash steps, the remainder by
// TABLE_SLOTS and the push into the queue, which waits while the queue is
// full, so it takes no new command until the last one is queued. The back end
// pops the queue and probes one slot a cycle through the registered key memory
// read port, visiting 1 to TABLE_SLOTS slots per command. Long probe chains
// fill the two-entry queue and then stretch busy. Each result shows for exactly
// one cycle with out_valid high and must be taken then; the receiver cannot
// stall the block.
module hashed_linear_probe_table import hlpt_pkg::*; #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  // command word
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [LEN_W-1:0]  in_name_length,
  input  logic [OFF_W-1:0]  in_name_offset,
  // result word
  output logic              out_valid,
  output logic [ST_W-1:0]   out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [LEN_W-1:0]  out_found_length,
  output logic [OFF_W-1:0]  out_found_offset
);

  localparam int IW = $clog2(TABLE_SLOTS);
  // queue word carries the home slot next to the command
  localparam int QW = IW + $bits(cmd_t);

  cmd_t          cmd_in;
  cmd_t          f_cmd;
  logic [IW-1:0] f_home;
  logic          f_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic [QW-1:0] q_data;
  cmd_t          b_cmd;
  logic [IW-1:0] b_home;
  logic          clearing;
  logic          res_valid;
  res_t          res;

  assign cmd_in.op  = in_operation;
  assign cmd_in.key = in_key;
  assign cmd_in.len = in_name_length;
  assign cmd_in.off = in_name_offset;

  // hash and home slot
  hlpt_front #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cmd_in   (cmd_in),
    .clearing (clearing),
    .busy     (busy),
    .q_full   (q_full),
    .q_push   (f_push),
    .q_cmd    (f_cmd),
    .q_home   (f_home)
  );

  // decouples hashing from probing
  hlpt_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_home, f_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign b_home = q_data[QW-1 -: IW];
  assign b_cmd  = cmd_t'(q_data[$bits(cmd_t)-1:0]);

  // memories and probe walk
  hlpt_back #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (b_cmd),
    .q_home    (b_home),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res       (res)
  );

  // results come straight from the back end's output register
  assign out_valid        = res_valid;
  assign out_status       = res.status;
  assign out_slot         = res.slot;
  assign out_found_length = res.length;
  assign out_found_offset = res.offset;

endmodule

FILE: rtl/core/hlpt_checker.sv
// port-level checker for the hashed linear probe table, with its bind
`include "assert_macros.svh"

module hlpt_checker import hlpt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [ST_W-1:0]   out_status,
  input logic [SLOT_W-1:0] out_slot,
  input logic [LEN_W-1:0]  out_found_length,
  input logic [OFF_W-1:0]  out_found_offset
);

  // payload only on a hit
  `ASSERT_IMPLY(a_payload_hit_only, clk, rst_n, out_valid && (out_status != ST_HIT), (out_found_length == '0) && (out_found_offset == '0))

  // no slot reported for full or miss
  `ASSERT_IMPLY(a_slot_zero, clk, rst_n, out_valid && ((out_status == ST_FULL) || (out_status == ST_MISS)), out_slot == '0)

  // an accepted command makes the block busy
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)

  // results never come in back-to-back cycles
  `ASSERT_NEXT(a_result_gap, clk, rst_n, out_valid, !out_valid)

  // clearing pass keeps the block busy right after reset
  `ASSERT_NEXT_ALWAYS(a_busy_after_reset, clk, !rst_n, busy)

endmodule

bind hashed_linear_probe_table hlpt_checker u_hlpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_slot         (out_slot),
  .out_found_length (out_found_length),
  .out_found_offset (out_found_offset)
);
